@@ hdl/bsws_pkg.sv @@
package bsws_pkg;

  // operation codes carried by an input word
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DUMP = 2'd2,
    OP_SWAP = 2'd3
  } opcode_e;

  // completion codes carried by a result word
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADINDEX  = 2'd3
  } status_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned IndexW = 4;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [IndexW-1:0]       index_t;

endpackage

@@ hdl/bsws_in_if.sv @@
interface bsws_in_if;
  logic                valid;
  logic                ready;
  bsws_pkg::opcode_e   opcode;
  bsws_pkg::data_t     push_value;
  bsws_pkg::index_t    index_a;
  bsws_pkg::index_t    index_b;

  modport source (output valid, output opcode, output push_value, output index_a,
                  output index_b, input ready);
  modport sink   (input valid, input opcode, input push_value, input index_a,
                  input index_b, output ready);
endinterface

@@ hdl/bsws_out_if.sv @@
interface bsws_out_if;
  logic                valid;
  logic                ready;
  bsws_pkg::data_t     read_value;
  bsws_pkg::status_e   status;
  logic                last;

  modport source (output valid, output read_value, output status, output last,
                  input ready);
  modport sink   (input valid, input read_value, input status, input last,
                  output ready);
endinterface

@@ hdl/bounded_stack_with_swap.sv @@
// channel | dir | handshake        | word
// in_i    | in  | valid / ready    | opcode, push_value, index_a, index_b
// out_o   | out | valid / ready    | read_value, status, last
//
// One item at a time. Push and a rejected op go from accept straight to the output load.
// Pop adds one read through the entry RAM. Swap adds two reads and two writes on the
// single-port-per-direction entry RAM. Dump repeats, for each stored word, one RAM
// read followed by one output load.
// Reset clears the fill count and the control state; entries stay unknown.
// A stalled output holds its word; a new input waits until the op completes.
module bounded_stack_with_swap #(
  parameter int unsigned DEPTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  bsws_in_if.sink   in_i,
  bsws_out_if.source out_o
);
  import bsws_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > IndexW) ? CntW : IndexW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_POP_RD = 3'd1;
  localparam logic [2:0] S_DMP_RD = 3'd2;
  localparam logic [2:0] S_SW_RA  = 3'd3;
  localparam logic [2:0] S_SW_RB  = 3'd4;
  localparam logic [2:0] S_SW_WB  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] addr_b_q, addr_b_d;
  logic [DataW-1:0] tmp_q, tmp_d;
  data_t            res_value_q, res_value_d;
  status_e          res_status_q, res_status_d;
  logic             res_last_q, res_last_d;

  logic             out_valid_q;
  data_t            out_value_q;
  status_e          out_status_q;
  logic             out_last_q;
  logic             load_out;
  logic             slot_free;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  logic             accept;
  logic             is_full, is_empty;
  logic [CmpW-1:0]  ia_ext, ib_ext, fill_ext;
  logic             swap_ok;
  logic [CntW-1:0]  idx_next_cnt;

  bsws_ram #(
    .Width(DataW),
    .Depth(DEPTH)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // input side and decode helpers
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign is_full    = (fill_q == CntW'(DEPTH));
  assign is_empty   = (fill_q == '0);
  assign ia_ext     = CmpW'(in_i.index_a);
  assign ib_ext     = CmpW'(in_i.index_b);
  assign fill_ext   = CmpW'(fill_q);
  assign swap_ok    = (ia_ext < fill_ext) && (ib_ext < fill_ext) && (ia_ext < ib_ext);
  assign idx_next_cnt = CntW'(idx_q) + CntW'(1);
  assign slot_free  = !out_valid_q || out_o.ready;

  // sequencer: read, modify, write back through the entry ram
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    addr_b_d     = addr_b_q;
    tmp_d        = tmp_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    load_out     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_value_d  = '0;
          res_status_d = ST_OK;
          res_last_d   = 1'b1;
          state_d      = S_EMIT;
          unique case (in_i.opcode)
            OP_PUSH: begin
              if (is_full) begin
                res_status_d = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = fill_q[AddrW-1:0];
                ram_wdata = in_i.push_value;
                fill_d    = fill_q + CntW'(1);
              end
            end
            OP_POP: begin
              if (is_empty) begin
                res_status_d = ST_UNDERFLOW;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AddrW'(fill_q - CntW'(1));
                fill_d    = fill_q - CntW'(1);
                state_d   = S_POP_RD;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                res_status_d = ST_UNDERFLOW;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = S_DMP_RD;
              end
            end
            OP_SWAP: begin
              if (is_empty) begin
                res_status_d = ST_UNDERFLOW;
              end else if (!swap_ok) begin
                res_status_d = ST_BADINDEX;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = ia_ext[AddrW-1:0];
                idx_d     = ia_ext[AddrW-1:0];
                addr_b_d  = ib_ext[AddrW-1:0];
                state_d   = S_SW_RA;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP_RD: begin
        res_value_d = ram_rdata;
        state_d     = S_EMIT;
      end
      S_DMP_RD: begin
        res_value_d  = ram_rdata;
        res_status_d = ST_OK;
        res_last_d   = (idx_next_cnt == fill_q);
        state_d      = S_EMIT;
      end
      S_SW_RA: begin
        tmp_d     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = addr_b_q;
        state_d   = S_SW_RB;
      end
      S_SW_RB: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        state_d   = S_SW_WB;
      end
      S_SW_WB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b_q;
        ram_wdata = tmp_q;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (res_last_q) begin
            state_d = S_IDLE;
          end else begin
            // next dump word
            idx_d     = idx_next_cnt[AddrW-1:0];
            ram_re    = 1'b1;
            ram_raddr = idx_next_cnt[AddrW-1:0];
            state_d   = S_DMP_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    addr_b_q     <= addr_b_d;
    tmp_q        <= tmp_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
    if (load_out) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_last_q   <= res_last_q;
    end
  end

  // output register
  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_value_q;
  assign out_o.status     = out_status_q;
  assign out_o.last       = out_last_q;

endmodule

@@ hdl/bsws_ram.sv @@
module bsws_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bsws_checker.sv @@
module bsws_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input bsws_pkg::data_t     out_value_i,
  input bsws_pkg::status_e   out_status_i,
  input logic                out_last_i
);
  import bsws_pkg::*;

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i) && $stable(out_status_i)
      && $stable(out_last_i))
    else $error("result word changed while stalled");

  // an error result is always a single zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> (out_value_i == '0) && out_last_i)
    else $error("error result with data or without last");

  // one operation at a time: no new word right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an operation is in flight");

endmodule

bind bounded_stack_with_swap bsws_checker u_bsws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.read_value),
  .out_status_i(out_o.status),
  .out_last_i  (out_o.last)
);

@@ tb/stack_monitor.sv @@
module stack_monitor #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bsws_in_if   in_mon,
  bsws_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   words_checked_o
);

  import bsws_pkg::*;

  typedef struct {
    data_t   value;
    status_e status;
    logic    last;
  } result_t;

  // shadow copy of the stack contents
  data_t       stack_mem [DEPTH];
  int unsigned stack_fill;

  // result words still owed by the block, oldest first
  result_t     awaited_q [$];

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    words_checked_o = 0;
    stack_fill      = 0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic queue_result(data_t value, status_e status, logic last);
    result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    awaited_q.push_back(r);
  endtask

  // apply one operation to the shadow stack and queue the words it owes
  task automatic predict_stack_op(opcode_e op, data_t value, index_t ia, index_t ib);
    data_t held;
    case (op)
      OP_PUSH: begin
        if (stack_fill >= DEPTH) begin
          queue_result('0, ST_OVERFLOW, 1'b1);
        end else begin
          stack_mem[stack_fill] = value;
          stack_fill++;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP: begin
        if (stack_fill == 0) begin
          queue_result('0, ST_UNDERFLOW, 1'b1);
        end else begin
          stack_fill--;
          queue_result(stack_mem[stack_fill], ST_OK, 1'b1);
        end
      end
      OP_DUMP: begin
        if (stack_fill == 0) begin
          queue_result('0, ST_UNDERFLOW, 1'b1);
        end else begin
          // bottom to top, last flag only on the top entry
          for (int i = 0; i < stack_fill; i++) begin
            queue_result(stack_mem[i], ST_OK, (i == stack_fill - 1));
          end
        end
      end
      default: begin
        if (stack_fill == 0) begin
          queue_result('0, ST_UNDERFLOW, 1'b1);
        end else if (ia < stack_fill && ib < stack_fill && ia < ib) begin
          held          = stack_mem[ia];
          stack_mem[ia] = stack_mem[ib];
          stack_mem[ib] = held;
          queue_result('0, ST_OK, 1'b1);
        end else begin
          queue_result('0, ST_BADINDEX, 1'b1);
        end
      end
    endcase
  endtask

  // compare one result word against the oldest owed word
  task automatic check_result(data_t value, status_e status, logic last);
    result_t want;
    if (awaited_q.size() == 0) begin
      report_mismatch($sformatf("result word with none owed: value %0d status %0d last %0b",
                                value, status, last));
      return;
    end
    want = awaited_q.pop_front();
    if (value !== want.value)
      report_mismatch($sformatf("read_value %0d, wanted %0d", value, want.value));
    if (status !== want.status)
      report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
    if (last !== want.last)
      report_mismatch($sformatf("last %0b, wanted %0b", last, want.last));
  endtask

  // watch both channels at each rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready)
        predict_stack_op(in_mon.opcode, in_mon.push_value, in_mon.index_a, in_mon.index_b);
      if (out_mon.valid && out_mon.ready) begin
        check_result(out_mon.read_value, out_mon.status, out_mon.last);
        words_checked_o++;
      end
      pending_o <= awaited_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
module testbench;

  import bsws_pkg::*;

  localparam int unsigned STACK_DEPTH    = 16;
  localparam int          TOTAL_ITEMS    = 410;
  localparam int          SQUEEZE_CYCLES = 300;
  localparam int          DRAIN_CYCLES   = 50;
  localparam longint      RUN_LIMIT      = 40_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bsws_in_if  in_if ();
  bsws_out_if out_if ();

  int fail_count;
  int pending;
  int words_checked;

  // stimulus side bookkeeping
  int          items_sent = 0;
  int          op_count [4] = '{default: 0};
  int unsigned stack_fill = 0;
  bit          tight = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeezed = 1'b0;

  bounded_stack_with_swap #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_i (in_if),
    .out_o(out_if)
  );

  stack_monitor #(
    .DEPTH(STACK_DEPTH)
  ) mon (
    .clk_i,
    .rst_ni,
    .in_mon         (in_if),
    .out_mon        (out_if),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .words_checked_o(words_checked)
  );

  always #4 clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // push values lean toward the extremes now and then
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return data_t'(32'h8000_0000);
      1:       return data_t'(32'h7FFF_FFFF);
      2:       return data_t'(32'hFFFF_FFFF);
      3:       return '0;
      default: return data_t'($urandom());
    endcase
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(opcode_e op, data_t value, index_t ia, index_t ib);
    int gap;
    gap = tight ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.push_value <= value;
    in_if.index_a    <= ia;
    in_if.index_b    <= ib;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    op_count[op]++;
    if (op == OP_PUSH && stack_fill < STACK_DEPTH) stack_fill++;
    if (op == OP_POP && stack_fill > 0) stack_fill--;
  endtask

  task automatic send_any();
    send_word(opcode_e'($urandom_range(0, 3)), pick_value(),
              index_t'($urandom_range(0, 15)), index_t'($urandom_range(0, 15)));
  endtask

  // swap inside the stored range, or a random one when too few entries
  task automatic send_good_swap();
    int unsigned a;
    int unsigned b;
    if (stack_fill < 2) begin
      send_word(OP_SWAP, pick_value(), index_t'($urandom_range(0, 15)),
                index_t'($urandom_range(0, 15)));
      return;
    end
    a = $urandom_range(0, stack_fill - 2);
    b = $urandom_range(a + 1, stack_fill - 1);
    send_word(OP_SWAP, pick_value(), index_t'(a), index_t'(b));
  endtask

  // receiver: random stalls, run-through stretches, one long hold-off on request
  initial begin
    int run;
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (squeeze_req) begin
        out_if.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        squeeze_req = 1'b0;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        out_if.ready <= 1'b1;
        repeat (run) @(posedge clk_i);
        stall = pick_gap();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // reset, directed words, random sequences, verdict
  initial begin
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_PUSH;
    in_if.push_value = '0;
    in_if.index_a    = '0;
    in_if.index_b    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack: every read-type op underflows
    send_word(OP_POP,  pick_value(), 4'd0, 4'd1);
    send_word(OP_DUMP, pick_value(), 4'd15, 4'd15);
    send_word(OP_SWAP, pick_value(), 4'd0, 4'd1);

    // extreme values, then the swap index rules
    send_word(OP_PUSH, data_t'(32'h8000_0000), 4'd0, 4'd0);
    send_word(OP_PUSH, data_t'(32'h7FFF_FFFF), 4'd0, 4'd0);
    send_word(OP_PUSH, data_t'(32'hFFFF_FFFF), 4'd0, 4'd0);
    send_word(OP_PUSH, '0, 4'd0, 4'd0);
    send_word(OP_SWAP, '0, 4'd0, 4'd1);
    send_word(OP_SWAP, '0, 4'd1, 4'd1);
    send_word(OP_SWAP, '0, 4'd2, 4'd1);
    send_word(OP_SWAP, '0, 4'd0, 4'd4);
    send_word(OP_DUMP, '0, 4'd0, 4'd0);
    send_word(OP_POP,  '0, 4'd0, 4'd0);

    // fill to the top, overflow, swap at the top end
    tight = 1'b1;
    while (stack_fill < STACK_DEPTH) send_word(OP_PUSH, pick_value(), 4'd0, 4'd0);
    send_word(OP_PUSH, pick_value(), 4'd0, 4'd0);
    send_word(OP_SWAP, '0, 4'd0, 4'd15);
    send_word(OP_SWAP, '0, 4'd14, 4'd15);

    // full dump against a held-off receiver, words keep coming
    squeeze_req = 1'b1;
    send_word(OP_DUMP, '0, 4'd0, 4'd0);
    repeat (3) send_word(OP_POP, '0, 4'd0, 4'd0);
    tight = 1'b0;

    // random sequences of pushes, pops, swaps and dumps
    while (items_sent < TOTAL_ITEMS) begin
      tight = ($urandom_range(0, 4) == 0);
      if (!squeezed && items_sent >= 200) begin
        squeezed    = 1'b1;
        squeeze_req = 1'b1;
        tight       = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 18)) send_word(OP_PUSH, pick_value(),
                   index_t'($urandom_range(0, 15)), index_t'($urandom_range(0, 15)));
        3, 4:    repeat ($urandom_range(1, 18)) send_word(OP_POP, pick_value(),
                   index_t'($urandom_range(0, 15)), index_t'($urandom_range(0, 15)));
        5, 6: begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0) send_word(OP_SWAP, pick_value(),
                index_t'($urandom_range(0, 15)), index_t'($urandom_range(0, 15)));
            else send_good_swap();
          end
        end
        7:       send_word(OP_DUMP, pick_value(),
                   index_t'($urandom_range(0, 15)), index_t'($urandom_range(0, 15)));
        default: repeat ($urandom_range(1, 4)) send_any();
      endcase
    end
    in_if.valid <= 1'b0;

    // let every owed word arrive, then watch for strays
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d words in (push %0d, pop %0d, dump %0d, swap %0d), %0d words out",
             items_sent, op_count[OP_PUSH], op_count[OP_POP], op_count[OP_DUMP],
             op_count[OP_SWAP], words_checked);
    $display("full and empty stack edges and long receiver hold-offs were included");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
